[rtl/bllca_pkg.sv]
// Package for the binary lifting LCA engine: widths, sizes, datapath op codes
// and the command and status structs between controller and datapath.
// No dependencies.
package bllca_pkg;

  localparam int NODE_W    = 10;
  localparam int DEPTH_W   = 11;
  localparam int NODES     = 2 ** NODE_W;
  localparam int LEVELS    = 11;
  localparam int LEVEL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ANC_DEPTH = NODES * (2 ** LEVEL_W);

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
  localparam logic [LEVEL_W-1:0] LAST_LVL  = LEVEL_W'(LEVELS - 1);

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT  = 5'd1;
  localparam logic [OP_W-1:0] OP_ROOT_WR = 5'd2;
  localparam logic [OP_W-1:0] OP_PDEP_RD = 5'd3;
  localparam logic [OP_W-1:0] OP_DEP_WR  = 5'd4;
  localparam logic [OP_W-1:0] OP_LANC_RD = 5'd5;
  localparam logic [OP_W-1:0] OP_LANC_WR = 5'd6;
  localparam logic [OP_W-1:0] OP_DA_RD   = 5'd7;
  localparam logic [OP_W-1:0] OP_DB_RD   = 5'd8;
  localparam logic [OP_W-1:0] OP_SWAP    = 5'd9;
  localparam logic [OP_W-1:0] OP_Q1_ANC  = 5'd10;
  localparam logic [OP_W-1:0] OP_Q1_DEP  = 5'd11;
  localparam logic [OP_W-1:0] OP_Q1_CMP  = 5'd12;
  localparam logic [OP_W-1:0] OP_Q2_RA   = 5'd13;
  localparam logic [OP_W-1:0] OP_Q2_RB   = 5'd14;
  localparam logic [OP_W-1:0] OP_Q2_CMP  = 5'd15;
  localparam logic [OP_W-1:0] OP_PAR_RD  = 5'd16;
  localparam logic [OP_W-1:0] OP_PAR_CAP = 5'd17;
  localparam logic [OP_W-1:0] OP_RDEP    = 5'd18;
  localparam logic [OP_W-1:0] OP_OUT     = 5'd19;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [LEVEL_W-1:0] lvl;
  } cmd_t;

  typedef struct packed {
    logic is_root;
    logic a_eq_b;
    logic out_free;
  } status_t;

endpackage

[rtl/bllca_dp.sv]
// Datapath of the LCA engine: ancestor and depth memories, walk registers
// and the result register. Executes one op per cycle from bllca_ctrl.
// Depends on bllca_pkg.
module bllca_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bllca_pkg::cmd_t                cmd,
  output bllca_pkg::status_t             status,
  input  logic [bllca_pkg::NODE_W-1:0]   in_node_a,
  input  logic [bllca_pkg::NODE_W-1:0]   in_node_b,
  input  logic [bllca_pkg::NODE_W-1:0]   in_parent,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bllca_pkg::NODE_W-1:0]   out_node,
  output logic [bllca_pkg::DEPTH_W-1:0]  out_depth
);

  localparam int NW  = bllca_pkg::NODE_W;
  localparam int DW  = bllca_pkg::DEPTH_W;
  localparam int LW  = bllca_pkg::LEVEL_W;
  localparam int AAW = NW + LW;

  logic [NW-1:0] anc_mem [bllca_pkg::ANC_DEPTH];
  logic [DW-1:0] dep_mem [bllca_pkg::NODES];

  logic [NW-1:0]  anc_rdata_r;
  logic [DW-1:0]  dep_rdata_r;

  logic           anc_we, anc_re, dep_we, dep_re;
  logic [AAW-1:0] anc_waddr, anc_raddr;
  logic [NW-1:0]  anc_wdata;
  logic [NW-1:0]  dep_waddr, dep_raddr;
  logic [DW-1:0]  dep_wdata;

  logic [NW-1:0]  a_r, a_nxt, b_r, b_nxt, cur_r, cur_nxt;
  logic [DW-1:0]  da_r, da_nxt, db_r, db_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [NW-1:0]  out_node_r, out_node_nxt;
  logic [DW-1:0]  out_depth_r, out_depth_nxt;

  logic [DW-1:0]  dep_inc;

  assign dep_inc = (dep_rdata_r == bllca_pkg::DEPTH_MAX) ? bllca_pkg::DEPTH_MAX
                                                         : dep_rdata_r + DW'(1);

  always_comb begin
    anc_we        = 1'b0;
    anc_re        = 1'b0;
    dep_we        = 1'b0;
    dep_re        = 1'b0;
    anc_waddr     = {a_r, cmd.lvl};
    anc_raddr     = {a_r, cmd.lvl};
    anc_wdata     = a_r;
    dep_waddr     = a_r;
    dep_raddr     = a_r;
    dep_wdata     = bllca_pkg::DEPTH_ONE;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    out_node_nxt  = out_node_r;
    out_depth_nxt = out_depth_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (cmd.op)
      bllca_pkg::OP_ACCEPT: begin
        a_nxt   = in_node_a;
        b_nxt   = in_node_b;
        cur_nxt = in_parent;
      end
      bllca_pkg::OP_ROOT_WR: begin
        anc_we = 1'b1;
        dep_we = 1'b1;
      end
      bllca_pkg::OP_PDEP_RD: begin
        dep_re    = 1'b1;
        dep_raddr = cur_r;
      end
      bllca_pkg::OP_DEP_WR: begin
        dep_we    = 1'b1;
        dep_wdata = dep_inc;
        anc_we    = 1'b1;
        anc_waddr = {a_r, LW'(0)};
        anc_wdata = cur_r;
      end
      bllca_pkg::OP_LANC_RD: begin
        anc_re    = 1'b1;
        anc_raddr = {cur_r, cmd.lvl};
      end
      bllca_pkg::OP_LANC_WR: begin
        anc_we    = 1'b1;
        anc_wdata = anc_rdata_r;
        cur_nxt   = anc_rdata_r;
      end
      bllca_pkg::OP_DA_RD: begin
        dep_re = 1'b1;
      end
      bllca_pkg::OP_DB_RD: begin
        dep_re    = 1'b1;
        dep_raddr = b_r;
        da_nxt    = dep_rdata_r;
      end
      bllca_pkg::OP_SWAP: begin
        if (da_r < dep_rdata_r) begin
          a_nxt  = b_r;
          b_nxt  = a_r;
          db_nxt = da_r;
        end else begin
          db_nxt = dep_rdata_r;
        end
      end
      bllca_pkg::OP_Q1_ANC: begin
        anc_re = 1'b1;
      end
      bllca_pkg::OP_Q1_DEP: begin
        cur_nxt   = anc_rdata_r;
        dep_re    = 1'b1;
        dep_raddr = anc_rdata_r;
      end
      bllca_pkg::OP_Q1_CMP: begin
        if (dep_rdata_r >= db_r) begin
          a_nxt = cur_r;
        end
      end
      bllca_pkg::OP_Q2_RA: begin
        anc_re = 1'b1;
      end
      bllca_pkg::OP_Q2_RB: begin
        cur_nxt   = anc_rdata_r;
        anc_re    = 1'b1;
        anc_raddr = {b_r, cmd.lvl};
      end
      bllca_pkg::OP_Q2_CMP: begin
        if (cur_r != anc_rdata_r) begin
          a_nxt = cur_r;
          b_nxt = anc_rdata_r;
        end
      end
      bllca_pkg::OP_PAR_RD: begin
        anc_re    = 1'b1;
        anc_raddr = {a_r, LW'(0)};
      end
      bllca_pkg::OP_PAR_CAP: begin
        a_nxt = anc_rdata_r;
      end
      bllca_pkg::OP_RDEP: begin
        dep_re = 1'b1;
      end
      bllca_pkg::OP_OUT: begin
        out_valid_nxt = 1'b1;
        out_node_nxt  = a_r;
        out_depth_nxt = dep_rdata_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (anc_we) begin
      anc_mem[anc_waddr] <= anc_wdata;
    end
    if (anc_re) begin
      anc_rdata_r <= anc_mem[anc_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[dep_waddr] <= dep_wdata;
    end
    if (dep_re) begin
      dep_rdata_r <= dep_mem[dep_raddr];
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    cur_r       <= cur_nxt;
    da_r        <= da_nxt;
    db_r        <= db_nxt;
    out_node_r  <= out_node_nxt;
    out_depth_r <= out_depth_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.is_root  = (in_node_a == in_parent);
  assign status.a_eq_b   = (a_r == b_r);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_node  = out_node_r;
  assign out_depth = out_depth_r;

endmodule

[rtl/bllca_ctrl.sv]
// Controller of the LCA engine: sequences loads and queries, keeps the level
// counter and issues at most one datapath op per cycle, none while it waits.
// Depends on bllca_pkg.
module bllca_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_query,
  output logic               in_ready,
  input  bllca_pkg::status_t status,
  output bllca_pkg::cmd_t    cmd
);

  localparam int LW = bllca_pkg::LEVEL_W;
  localparam int SW = 5;

  localparam logic [SW-1:0] S_IDLE = 5'd0;
  localparam logic [SW-1:0] S_ROOT = 5'd1;
  localparam logic [SW-1:0] S_PDEP = 5'd2;
  localparam logic [SW-1:0] S_DEPW = 5'd3;
  localparam logic [SW-1:0] S_LRD  = 5'd4;
  localparam logic [SW-1:0] S_LWR  = 5'd5;
  localparam logic [SW-1:0] S_QDA  = 5'd6;
  localparam logic [SW-1:0] S_QDB  = 5'd7;
  localparam logic [SW-1:0] S_SWAP = 5'd8;
  localparam logic [SW-1:0] S_Q1A  = 5'd9;
  localparam logic [SW-1:0] S_Q1D  = 5'd10;
  localparam logic [SW-1:0] S_Q1C  = 5'd11;
  localparam logic [SW-1:0] S_EQ   = 5'd12;
  localparam logic [SW-1:0] S_Q2A  = 5'd13;
  localparam logic [SW-1:0] S_Q2B  = 5'd14;
  localparam logic [SW-1:0] S_Q2C  = 5'd15;
  localparam logic [SW-1:0] S_PAR  = 5'd16;
  localparam logic [SW-1:0] S_PARC = 5'd17;
  localparam logic [SW-1:0] S_RDEP = 5'd18;
  localparam logic [SW-1:0] S_OUT  = 5'd19;

  logic [SW-1:0] state_r, state_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    in_ready  = 1'b0;
    cmd.op    = bllca_pkg::OP_NONE;
    cmd.lvl   = lvl_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.op  = bllca_pkg::OP_ACCEPT;
          lvl_nxt = '0;
          if (in_query) begin
            state_nxt = S_QDA;
          end else if (status.is_root) begin
            state_nxt = S_ROOT;
          end else begin
            state_nxt = S_PDEP;
          end
        end
      end
      S_ROOT: begin
        cmd.op = bllca_pkg::OP_ROOT_WR;
        if (lvl_r == bllca_pkg::LAST_LVL) begin
          state_nxt = S_IDLE;
        end else begin
          lvl_nxt = lvl_r + LW'(1);
        end
      end
      S_PDEP: begin
        cmd.op    = bllca_pkg::OP_PDEP_RD;
        state_nxt = S_DEPW;
      end
      S_DEPW: begin
        cmd.op  = bllca_pkg::OP_DEP_WR;
        lvl_nxt = LW'(1);
        if (bllca_pkg::LEVELS == 1) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LRD;
        end
      end
      S_LRD: begin
        cmd.op    = bllca_pkg::OP_LANC_RD;
        cmd.lvl   = lvl_r - LW'(1);
        state_nxt = S_LWR;
      end
      S_LWR: begin
        cmd.op = bllca_pkg::OP_LANC_WR;
        if (lvl_r == bllca_pkg::LAST_LVL) begin
          state_nxt = S_IDLE;
        end else begin
          lvl_nxt   = lvl_r + LW'(1);
          state_nxt = S_LRD;
        end
      end
      S_QDA: begin
        cmd.op    = bllca_pkg::OP_DA_RD;
        state_nxt = S_QDB;
      end
      S_QDB: begin
        cmd.op    = bllca_pkg::OP_DB_RD;
        state_nxt = S_SWAP;
      end
      S_SWAP: begin
        cmd.op    = bllca_pkg::OP_SWAP;
        lvl_nxt   = bllca_pkg::LAST_LVL;
        state_nxt = S_Q1A;
      end
      S_Q1A: begin
        cmd.op    = bllca_pkg::OP_Q1_ANC;
        state_nxt = S_Q1D;
      end
      S_Q1D: begin
        cmd.op    = bllca_pkg::OP_Q1_DEP;
        state_nxt = S_Q1C;
      end
      S_Q1C: begin
        cmd.op = bllca_pkg::OP_Q1_CMP;
        if (lvl_r == '0) begin
          state_nxt = S_EQ;
        end else begin
          lvl_nxt   = lvl_r - LW'(1);
          state_nxt = S_Q1A;
        end
      end
      S_EQ: begin
        if (status.a_eq_b) begin
          state_nxt = S_RDEP;
        end else begin
          lvl_nxt   = bllca_pkg::LAST_LVL;
          state_nxt = S_Q2A;
        end
      end
      S_Q2A: begin
        cmd.op    = bllca_pkg::OP_Q2_RA;
        state_nxt = S_Q2B;
      end
      S_Q2B: begin
        cmd.op    = bllca_pkg::OP_Q2_RB;
        state_nxt = S_Q2C;
      end
      S_Q2C: begin
        cmd.op = bllca_pkg::OP_Q2_CMP;
        if (lvl_r == '0) begin
          state_nxt = S_PAR;
        end else begin
          lvl_nxt   = lvl_r - LW'(1);
          state_nxt = S_Q2A;
        end
      end
      S_PAR: begin
        cmd.op    = bllca_pkg::OP_PAR_RD;
        state_nxt = S_PARC;
      end
      S_PARC: begin
        cmd.op    = bllca_pkg::OP_PAR_CAP;
        state_nxt = S_RDEP;
      end
      S_RDEP: begin
        cmd.op    = bllca_pkg::OP_RDEP;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op    = bllca_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lvl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

endmodule

[rtl/binary_lifting_lca_engine.sv]
// Top level of the binary lifting LCA engine: stream ports, controller and
// datapath. Depends on bllca_pkg, bllca_ctrl and bllca_dp.
//
// Holds a rooted tree of up to 1024 nodes as an ancestor table (2^j-th
// ancestor per level, 11 levels) plus a depth per node; the root is loaded
// with parent equal to itself and has depth 1, and a parent must be loaded
// before its children. One item is worked on at a time; in_tready is high
// only while the block is idle. Timing is set by the single read port of
// the ancestor memory and of the depth memory: a root load writes every
// level, any other load does one read and one write per level, and a query
// takes a shorter path when one node is an ancestor of the other. The next
// item is accepted while a result still waits on out_tready. No clearing
// pass after reset: reading a node never loaded gives an unspecified answer.
module binary_lifting_lca_engine (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [9:0] node_a, [19:10] node_b, [29:20] parent_node, [31:30] zero
  input  logic [bllca_pkg::IN_DATA_W-1:0]       in_tdata,
  // [0] req_type
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [9:0] ancestor_node, [20:10] ancestor_depth, [23:21] zero
  output logic [bllca_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int NW = bllca_pkg::NODE_W;
  localparam int DW = bllca_pkg::DEPTH_W;

  bllca_pkg::cmd_t    cmd;
  bllca_pkg::status_t status;

  logic [NW-1:0] out_node;
  logic [DW-1:0] out_depth;

  bllca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_query (in_tuser),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bllca_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_node_a (in_tdata[NW-1:0]),
    .in_node_b (in_tdata[2*NW-1:NW]),
    .in_parent (in_tdata[3*NW-1:2*NW]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_node  (out_node),
    .out_depth (out_depth)
  );

  assign out_tdata = {{(bllca_pkg::OUT_DATA_W - NW - DW){1'b0}}, out_depth, out_node};

endmodule
